FILE: src/pars_pkg.sv
// shared types and constants for the power and reflash sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pars_pkg;

  localparam int unsigned ANIM_IDX_W = 4;
  localparam int unsigned ANIM_BRI_W = 6;
  localparam int unsigned BL_W       = 8;
  localparam int unsigned FIELD_T_W  = 16;

  typedef logic [ANIM_IDX_W-1:0] anim_idx_t;
  typedef logic [ANIM_BRI_W-1:0] anim_bri_t;
  typedef logic [BL_W-1:0]       bl_t;
  typedef logic [FIELD_T_W-1:0]  field_time_t;

  // reflash and bootloader timing in ms
  localparam logic [31:0] DTR_LOW_MIN   = 32'd80;
  localparam logic [31:0] DTR_LOW_MAX   = 32'd1600;
  localparam logic [31:0] REFLASH_BOOT  = 32'd100;
  localparam logic [31:0] REFLASH_EN    = 32'd200;
  localparam logic [31:0] REFLASH_DONE  = 32'd300;
  localparam logic [31:0] BOOT_DISABLE  = 32'd5000;
  localparam logic [31:0] BOOT_CLOSE    = 32'd5100;
  localparam logic [31:0] ANIM_PERIOD   = 32'd100;

  localparam bl_t BL_RESET = 8'd255;

  function automatic anim_bri_t anim_lookup(input anim_idx_t idx);
    anim_bri_t bri;
    unique case (idx)
      4'd0, 4'd10:  bri = 6'd1;
      4'd1, 4'd9,
      4'd11:        bri = 6'd2;
      4'd2, 4'd8,
      4'd12:        bri = 6'd4;
      4'd3, 4'd7,
      4'd13:        bri = 6'd8;
      4'd4, 4'd6,
      4'd14:        bri = 6'd16;
      4'd5, 4'd15:  bri = 6'd32;
      default:      bri = 6'd1;
    endcase
    return bri;
  endfunction

endpackage

`default_nettype wire

FILE: src/power_and_reflash_sequencer.sv
// power and reflash sequencer top level: input register, tick logic, result register
// depends on pars_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   one item per millisecond tick arrives on the in_ channel (valid/ready) with the
//   time, switch edges, modem line levels, host activity, last transmit time and
//   charger status. each item gives exactly one result on the out_ channel with the
//   drive levels, LED reinit pulse, charge animation step and bootloader flag.
//   cfg_ carries the backlight brightness; it is always ready and should only be
//   written while no item is in flight.
// Flow and throughput
//   an item is registered at acceptance, evaluated against the block state once the
//   result register is free or being taken, then lands there; out_valid rises as
//   that register is loaded.
//   one item per cycle while out_ready is high; the update is a single short stage.
// Reset
//   rst_n low clears all power, reflash and animation state, sets the brightness
//   register to 255 and empties both pipeline registers.
// Stalls
//   when out_ready is low the result holds; one more item may wait in the input
//   register, after which in_ready drops until the result is taken.
module power_and_reflash_sequencer #(
  parameter int unsigned ANIM_STEPS = 10,
  parameter int unsigned TIME_BITS  = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [7:0]                 cfg_backlight_brightness,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [15:0]                in_now_ms,
  input  wire logic                       in_switch_rise,
  input  wire logic                       in_switch_fall,
  input  wire logic                       in_uart_updated,
  input  wire logic                       in_dtr,
  input  wire logic                       in_rts,
  input  wire logic                       in_host_active,
  input  wire logic [15:0]                in_last_tx_ms,
  input  wire logic                       in_battery_charging,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_powered_on,
  output logic                            out_charge_high_current,
  output logic                            out_module_enable,
  output logic                            out_boot_select_active,
  output logic [7:0]                      out_backlight_level,
  output logic                            out_led_reinit,
  output logic                            out_anim_update,
  output logic                            out_anim_charged,
  output logic [5:0]                      out_anim_brightness,
  output logic                            out_in_bootloader
);

  typedef logic [TIME_BITS-1:0] tm_t;

  localparam int unsigned ANIM_IDX_W_P1 = pars_pkg::ANIM_IDX_W + 1;
  localparam logic [ANIM_IDX_W_P1-1:0] ANIM_WRAP = ANIM_IDX_W_P1'(ANIM_STEPS);

  // input register
  logic                   s1_valid_r;
  pars_pkg::field_time_t  s1_now_r, s1_last_tx_r;
  logic                   s1_rise_r, s1_fall_r, s1_uart_r, s1_dtr_r, s1_rts_r;
  logic                   s1_host_r, s1_charging_r;

  // block state
  pars_pkg::bl_t     bright_r;
  logic              physical_on_r, virtual_on_r, flags_changed_r, power_state_r;
  logic              bootloader_r;
  tm_t               dtr_low_start_r, reflash_start_r, anim_last_r;
  pars_pkg::anim_idx_t anim_index_r;
  logic              drv_enable_r, drv_boot_r, drv_high_r;
  pars_pkg::bl_t     drv_bl_r;

  logic              out_valid_r;
  logic              advance;

  // next state
  logic              physical_on_nxt, virtual_on_nxt, flags_changed_nxt, power_state_nxt;
  logic              bootloader_nxt;
  tm_t               dtr_low_start_nxt, reflash_start_nxt, anim_last_nxt;
  pars_pkg::anim_idx_t anim_index_nxt;
  logic              drv_enable_nxt, drv_boot_nxt, drv_high_nxt;
  pars_pkg::bl_t     drv_bl_nxt;
  logic              reinit_nxt, anim_upd_nxt, anim_chg_nxt;
  pars_pkg::anim_bri_t anim_bri_nxt;

  tm_t               now_t, last_tx_t, d_dtr, d_reflash, d_tx, d_anim;
  logic [ANIM_IDX_W_P1-1:0] anim_step;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // time fields cut or widened to the internal time width
  assign now_t     = TIME_BITS'({{(TIME_BITS > 16 ? TIME_BITS - 16 : 1){1'b0}}, s1_now_r});
  assign last_tx_t = TIME_BITS'({{(TIME_BITS > 16 ? TIME_BITS - 16 : 1){1'b0}}, s1_last_tx_r});

  always_comb begin
    physical_on_nxt   = physical_on_r;
    virtual_on_nxt    = virtual_on_r;
    flags_changed_nxt = flags_changed_r;
    power_state_nxt   = power_state_r;
    bootloader_nxt    = bootloader_r;
    dtr_low_start_nxt = dtr_low_start_r;
    reflash_start_nxt = reflash_start_r;
    anim_last_nxt     = anim_last_r;
    anim_index_nxt    = anim_index_r;
    drv_enable_nxt    = drv_enable_r;
    drv_boot_nxt      = drv_boot_r;
    drv_high_nxt      = drv_high_r;
    drv_bl_nxt        = drv_bl_r;
    reinit_nxt        = 1'b0;
    anim_upd_nxt      = 1'b0;
    anim_chg_nxt      = 1'b0;
    anim_bri_nxt      = '0;
    anim_step         = '0;

    if (s1_rise_r) begin
      physical_on_nxt   = 1'b1;
      flags_changed_nxt = 1'b1;
    end
    if (s1_fall_r) begin
      physical_on_nxt   = 1'b0;
      flags_changed_nxt = 1'b1;
    end
    if (!virtual_on_nxt && s1_host_r) begin
      virtual_on_nxt    = 1'b1;
      flags_changed_nxt = 1'b1;
    end

    if (flags_changed_nxt) begin
      flags_changed_nxt = 1'b0;
      if (physical_on_nxt || virtual_on_nxt) begin
        power_state_nxt = 1'b1;
        drv_high_nxt    = 1'b0;
      end else begin
        power_state_nxt = 1'b0;
        drv_high_nxt    = 1'b1;
        anim_last_nxt   = now_t;
        anim_index_nxt  = '0;
      end
      reinit_nxt = 1'b1;
    end

    // dtr low pulse followed by rts starts a reflash
    d_dtr = now_t - dtr_low_start_r;
    if (s1_uart_r) begin
      if (!s1_dtr_r) begin
        dtr_low_start_nxt = now_t;
      end else begin
        if (s1_rts_r && dtr_low_start_r != '0 &&
            32'(d_dtr) > pars_pkg::DTR_LOW_MIN && 32'(d_dtr) < pars_pkg::DTR_LOW_MAX) begin
          virtual_on_nxt    = 1'b1;
          flags_changed_nxt = 1'b1;
          reflash_start_nxt = now_t;
          drv_enable_nxt    = 1'b0;
          drv_bl_nxt        = '0;
        end
        dtr_low_start_nxt = '0;
      end
    end

    d_reflash = now_t - reflash_start_nxt;
    d_tx      = now_t - last_tx_t;
    if (reflash_start_nxt != '0) begin
      priority if (32'(d_reflash) > pars_pkg::REFLASH_DONE) begin
        drv_boot_nxt      = 1'b0;
        reflash_start_nxt = '0;
      end else if (32'(d_reflash) > pars_pkg::REFLASH_EN) begin
        drv_enable_nxt = 1'b1;
        drv_bl_nxt     = bright_r;
      end else if (32'(d_reflash) > pars_pkg::REFLASH_BOOT) begin
        drv_boot_nxt   = 1'b1;
        bootloader_nxt = 1'b1;
      end else begin
        // lines hold until the boot step
      end
    end else if (bootloader_nxt) begin
      priority if (32'(d_tx) > pars_pkg::BOOT_CLOSE) begin
        bootloader_nxt = 1'b0;
      end else if (32'(d_tx) > pars_pkg::BOOT_DISABLE) begin
        drv_enable_nxt = 1'b0;
        drv_bl_nxt     = '0;
      end else begin
        // lines hold inside the window
      end
    end else if (power_state_nxt) begin
      drv_enable_nxt = 1'b1;
      drv_bl_nxt     = bright_r;
    end else begin
      drv_enable_nxt = 1'b0;
      drv_bl_nxt     = '0;
    end

    // charge animation while powered off
    d_anim = now_t - anim_last_nxt;
    if (!power_state_nxt && 32'(d_anim) >= pars_pkg::ANIM_PERIOD) begin
      anim_upd_nxt = 1'b1;
      anim_chg_nxt = !s1_charging_r;
      anim_bri_nxt = pars_pkg::anim_lookup(anim_index_nxt);
      anim_step    = {1'b0, anim_index_nxt} + ANIM_IDX_W_P1'(1);
      if (anim_step >= ANIM_WRAP) begin
        anim_index_nxt = '0;
      end else begin
        anim_index_nxt = anim_step[pars_pkg::ANIM_IDX_W-1:0];
      end
      anim_last_nxt = now_t;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now_r      <= in_now_ms;
      s1_rise_r     <= in_switch_rise;
      s1_fall_r     <= in_switch_fall;
      s1_uart_r     <= in_uart_updated;
      s1_dtr_r      <= in_dtr;
      s1_rts_r      <= in_rts;
      s1_host_r     <= in_host_active;
      s1_last_tx_r  <= in_last_tx_ms;
      s1_charging_r <= in_battery_charging;
    end
    if (advance) begin
      out_powered_on          <= power_state_nxt;
      out_charge_high_current <= drv_high_nxt;
      out_module_enable       <= drv_enable_nxt;
      out_boot_select_active  <= drv_boot_nxt;
      out_backlight_level     <= drv_bl_nxt;
      out_led_reinit          <= reinit_nxt;
      out_anim_update         <= anim_upd_nxt;
      out_anim_charged        <= anim_chg_nxt;
      out_anim_brightness     <= anim_bri_nxt;
      out_in_bootloader       <= bootloader_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      bright_r        <= pars_pkg::BL_RESET;
      physical_on_r   <= 1'b0;
      virtual_on_r    <= 1'b0;
      flags_changed_r <= 1'b0;
      power_state_r   <= 1'b0;
      bootloader_r    <= 1'b0;
      dtr_low_start_r <= '0;
      reflash_start_r <= '0;
      anim_last_r     <= '0;
      anim_index_r    <= '0;
      drv_enable_r    <= 1'b0;
      drv_boot_r      <= 1'b0;
      drv_high_r      <= 1'b0;
      drv_bl_r        <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        bright_r <= cfg_backlight_brightness;
      end
      if (advance) begin
        physical_on_r   <= physical_on_nxt;
        virtual_on_r    <= virtual_on_nxt;
        flags_changed_r <= flags_changed_nxt;
        power_state_r   <= power_state_nxt;
        bootloader_r    <= bootloader_nxt;
        dtr_low_start_r <= dtr_low_start_nxt;
        reflash_start_r <= reflash_start_nxt;
        anim_last_r     <= anim_last_nxt;
        anim_index_r    <= anim_index_nxt;
        drv_enable_r    <= drv_enable_nxt;
        drv_boot_r      <= drv_boot_nxt;
        drv_high_r      <= drv_high_nxt;
        drv_bl_r        <= drv_bl_nxt;
      end
    end
  end

  // input side only stalls when both registers are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low without a blocked result");

  // no animation while powered
  a_anim_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_powered_on) |-> !out_anim_update)
    else $error("animation step issued while powered on");

  // an idle animation slot carries no pattern
  a_anim_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_anim_update) |-> (out_anim_brightness == '0 && !out_anim_charged))
    else $error("animation fields set without an update");

  // powered on always selects the low charge current
  a_charge_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_powered_on) |-> !out_charge_high_current)
    else $error("high charge current while powered on");

  // animation index stays inside the configured range
  a_anim_range: assert property (@(posedge clk) disable iff (!rst_n)
    ANIM_IDX_W_P1'({1'b0, anim_index_r}) < ANIM_WRAP || anim_index_r == '0)
    else $error("animation index out of range");

endmodule

`default_nettype wire
